@@ hw/rtl/sspi_pkg.sv @@
// Shared types, constants and helpers for the scheduled speed PI loop.
package sspi_pkg;

  localparam int unsigned MaxWaypointsDef = 16;
  localparam int unsigned TimeBitsDef     = 32;

  localparam int unsigned GainW   = 24;
  localparam int unsigned LimitW  = 19;
  localparam int unsigned CountW  = 5;
  localparam int unsigned SpeedW  = 24;
  localparam int unsigned ErrW    = 25;
  localparam int unsigned CmdW    = 20;
  localparam int unsigned WpIdxW  = 4;
  localparam int unsigned WpTimeW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned ProdW   = 49;  // gain * error, Q.24 or Q.32
  localparam int unsigned AccW    = 48;  // integral, Q23.24
  localparam int unsigned WideW   = 51;  // headroom for sums before saturation
  localparam int unsigned FracShift = 16; // Q.24 limit/output vs Q.8 current

  localparam logic [GainW-1:0]  KpReset    = 24'd32768;  // 0.5
  localparam logic [GainW-1:0]  KiReset    = 24'd33554;  // 2.0 * 1 ms
  localparam logic [LimitW-1:0] LimitReset = 19'd28160;  // 110.0 A
  localparam logic [CountW-1:0] CountReset = 5'd0;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP    = 2'd0,
    CFG_KI    = 2'd1,
    CFG_LIMIT = 2'd2,
    CFG_COUNT = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_ERROR,
    ST_MUL_KI,
    ST_INTEG,
    ST_SUM,
    ST_CLAMP,
    ST_EXCESS,
    ST_WIND,
    ST_OUT
  } state_e;

  // Saturate a wide signed sum to the signed integral range.
  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [WideW-1:0] x);
    logic [WideW-AccW:0] top;
    top = x[WideW-1:AccW-1];
    if ((top == '0) || (top == '1)) begin
      return x[AccW-1:0];
    end else if (x[WideW-1]) begin
      return {1'b1, {(AccW-1){1'b0}}};
    end else begin
      return {1'b0, {(AccW-1){1'b1}}};
    end
  endfunction

endpackage

@@ hw/rtl/scheduled_speed_pi_loop.sv @@
// A tick scans the first N = min(waypoint_count, MAX_WAYPOINTS) waypoints, highest index first.
// Each entry is read in SCAN_RD and compared in SCAN_CMP via the single registered read port.
// The PI step then runs ERROR to WIND on one shared 25x25 multiplier and adder chain.
// Ticks and writes enter only in IDLE, once the last result is loaded; a write gives no result.
// Reset clears config to defaults, the tick counter, integral and speed-seen flag.
// Table contents are undefined after reset until written; there is no clearing pass.
module scheduled_speed_pi_loop #(
  parameter int unsigned MAX_WAYPOINTS = sspi_pkg::MaxWaypointsDef,
  parameter int unsigned TIME_BITS     = sspi_pkg::TimeBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sspi_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [sspi_pkg::CfgDataW-1:0]        cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 opcode_i,
  input  logic signed [sspi_pkg::SpeedW-1:0]   speed_measured_i,
  input  logic                                 speed_present_i,
  input  logic [sspi_pkg::WpIdxW-1:0]          waypoint_index_i,
  input  logic [sspi_pkg::WpTimeW-1:0]         waypoint_time_i,
  input  logic signed [sspi_pkg::SpeedW-1:0]   waypoint_speed_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [sspi_pkg::CmdW-1:0]     current_command_o,
  output logic                                 at_limit_o,
  output logic signed [sspi_pkg::SpeedW-1:0]   speed_target_o
);

  localparam int unsigned AddrW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_WAYPOINTS + 1);
  localparam int unsigned CmpW  = (CntW > 5) ? CntW : 5;
  localparam int unsigned W     = sspi_pkg::WideW;

  sspi_pkg::state_e state_q, state_d;

  // config
  logic [sspi_pkg::GainW-1:0]  kp_q, ki_q;
  logic [sspi_pkg::LimitW-1:0] limit_q;
  logic [sspi_pkg::CountW-1:0] count_q;

  // architectural state
  logic [TIME_BITS-1:0]              tick_q;
  logic signed [sspi_pkg::AccW-1:0]  integ_q;
  logic                              speed_seen_q;
  logic                              out_valid_q;

  // working registers
  logic [CntW-1:0]                    rem_q;
  logic signed [sspi_pkg::SpeedW-1:0] meas_q, target_q;
  logic signed [sspi_pkg::ErrW-1:0]   err_q;
  logic signed [sspi_pkg::ProdW-1:0]  prod_q;
  logic signed [W-1:0]                sum_q, clamped_q;
  logic                               clip_q;

  // output word
  logic signed [sspi_pkg::CmdW-1:0]   cmd_q;
  logic                               at_limit_q;
  logic signed [sspi_pkg::SpeedW-1:0] tgt_out_q;

  // sequencer controls
  logic                       tick_fire, wr_fire, rd_en, ld_out, use_kp;
  logic [AddrW-1:0]           rd_addr;

  // table
  logic                               tbl_we;
  logic [TIME_BITS-1:0]               rd_time;
  logic signed [sspi_pkg::SpeedW-1:0] rd_speed;

  // datapath
  logic [CntW-1:0]                    count_eff;
  logic                               time_hit;
  logic signed [sspi_pkg::ErrW-1:0]   mul_a;
  logic signed [2*sspi_pkg::ErrW-1:0] mul_p;
  logic signed [W-1:0]                lim_pos, lim_neg;

  assign cfg_ready_o = 1'b1;

  assign count_eff = (CmpW'(count_q) > CmpW'(MAX_WAYPOINTS)) ? CntW'(MAX_WAYPOINTS)
                                                              : CntW'(count_q);
  assign time_hit  = (tick_q >= rd_time);
  assign tbl_we    = wr_fire && (CmpW'(waypoint_index_i) < CmpW'(MAX_WAYPOINTS));

  // shared multiplier: ki in MUL_KI, kp in INTEG
  assign mul_a = use_kp ? signed'({1'b0, kp_q}) : signed'({1'b0, ki_q});
  assign mul_p = mul_a * err_q;

  assign lim_pos = signed'(W'({limit_q, {sspi_pkg::FracShift{1'b0}}}));
  assign lim_neg = -lim_pos;

  sspi_table #(
    .DEPTH  (MAX_WAYPOINTS),
    .TIME_W (TIME_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .wr_en_i    (tbl_we),
    .wr_addr_i  (AddrW'(waypoint_index_i)),
    .wr_time_i  (TIME_BITS'(waypoint_time_i)),
    .wr_speed_i (waypoint_speed_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_time_o  (rd_time),
    .rd_speed_o (rd_speed)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sspi_pkg::ST_IDLE:     if (tick_fire) state_d = sspi_pkg::ST_SCAN_RD;
      sspi_pkg::ST_SCAN_RD:  state_d = (rem_q == '0) ? sspi_pkg::ST_ERROR
                                                     : sspi_pkg::ST_SCAN_CMP;
      sspi_pkg::ST_SCAN_CMP: state_d = time_hit ? sspi_pkg::ST_ERROR : sspi_pkg::ST_SCAN_RD;
      sspi_pkg::ST_ERROR:    state_d = speed_seen_q ? sspi_pkg::ST_MUL_KI : sspi_pkg::ST_OUT;
      sspi_pkg::ST_MUL_KI:   state_d = sspi_pkg::ST_INTEG;
      sspi_pkg::ST_INTEG:    state_d = sspi_pkg::ST_SUM;
      sspi_pkg::ST_SUM:      state_d = sspi_pkg::ST_CLAMP;
      sspi_pkg::ST_CLAMP:    state_d = sspi_pkg::ST_EXCESS;
      sspi_pkg::ST_EXCESS:   state_d = sspi_pkg::ST_WIND;
      sspi_pkg::ST_WIND:     state_d = sspi_pkg::ST_OUT;
      sspi_pkg::ST_OUT:      if (ld_out) state_d = sspi_pkg::ST_IDLE;
      default:               state_d = sspi_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = (state_q == sspi_pkg::ST_IDLE);
    tick_fire  = in_ready_o && in_valid_i && (opcode_i == sspi_pkg::OP_TICK);
    wr_fire    = in_ready_o && in_valid_i && (opcode_i == sspi_pkg::OP_WRITE);
    rd_en      = (state_q == sspi_pkg::ST_SCAN_RD) && (rem_q != '0);
    rd_addr    = AddrW'(rem_q - CntW'(1));
    use_kp     = (state_q == sspi_pkg::ST_INTEG);
    ld_out     = (state_q == sspi_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sspi_pkg::ST_IDLE;
      kp_q         <= sspi_pkg::KpReset;
      ki_q         <= sspi_pkg::KiReset;
      limit_q      <= sspi_pkg::LimitReset;
      count_q      <= sspi_pkg::CountReset;
      tick_q       <= '0;
      integ_q      <= '0;
      speed_seen_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (sspi_pkg::cfg_idx_e'(cfg_index_i))
          sspi_pkg::CFG_KP:    kp_q    <= cfg_data_i[sspi_pkg::GainW-1:0];
          sspi_pkg::CFG_KI:    ki_q    <= cfg_data_i[sspi_pkg::GainW-1:0];
          sspi_pkg::CFG_LIMIT: limit_q <= cfg_data_i[sspi_pkg::LimitW-1:0];
          sspi_pkg::CFG_COUNT: count_q <= cfg_data_i[sspi_pkg::CountW-1:0];
          default: ;
        endcase
      end
      if (tick_fire) begin
        if (tick_q != '1) tick_q <= tick_q + TIME_BITS'(1);
        if (speed_present_i) speed_seen_q <= 1'b1;
      end
      if (state_q == sspi_pkg::ST_INTEG) begin
        integ_q <= sspi_pkg::sat_acc(W'(integ_q) + W'(prod_q >>> 8));
      end
      if (state_q == sspi_pkg::ST_WIND) begin
        integ_q <= sspi_pkg::sat_acc(W'(integ_q) - sum_q);
      end
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      sspi_pkg::ST_IDLE: begin
        if (tick_fire) begin
          meas_q    <= speed_measured_i;
          rem_q     <= count_eff;
          target_q  <= '0;
          clamped_q <= '0;
          clip_q    <= 1'b0;
        end
      end
      sspi_pkg::ST_SCAN_RD: begin
        if (rem_q != '0) rem_q <= rem_q - CntW'(1);
      end
      sspi_pkg::ST_SCAN_CMP: begin
        if (time_hit) target_q <= rd_speed;
      end
      sspi_pkg::ST_ERROR: begin
        err_q <= sspi_pkg::ErrW'(target_q) - sspi_pkg::ErrW'(meas_q);
      end
      sspi_pkg::ST_MUL_KI, sspi_pkg::ST_INTEG: begin
        prod_q <= mul_p[sspi_pkg::ProdW-1:0];
      end
      sspi_pkg::ST_SUM: begin
        sum_q <= W'(prod_q) + W'(integ_q);
      end
      sspi_pkg::ST_CLAMP: begin
        if (sum_q > lim_pos) begin
          clamped_q <= lim_pos;
          clip_q    <= 1'b1;
        end else if (sum_q < lim_neg) begin
          clamped_q <= lim_neg;
          clip_q    <= 1'b1;
        end else begin
          clamped_q <= sum_q;
        end
      end
      sspi_pkg::ST_EXCESS: begin
        // excess over the clamp, zero when not clipped
        sum_q <= sum_q - clamped_q;
      end
      default: ;
    endcase
    if (ld_out) begin
      cmd_q      <= clamped_q[sspi_pkg::FracShift+sspi_pkg::CmdW-1:sspi_pkg::FracShift];
      at_limit_q <= clip_q;
      tgt_out_q  <= target_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign current_command_o = cmd_q;
  assign at_limit_o        = at_limit_q;
  assign speed_target_o    = tgt_out_q;

`ifndef SYNTH
  // a clipped word sits exactly on one of the two rails
  a_clip_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && at_limit_o |->
      (W'(current_command_o) == W'(signed'({1'b0, limit_q}))) ||
      (W'(current_command_o) == -W'(signed'({1'b0, limit_q}))))
    else $error("clipped command not on the current limit");

  // no drive and no clipping before a speed measurement
  a_no_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !speed_seen_q |-> (current_command_o == '0) && !at_limit_o)
    else $error("command issued before any speed measurement");

  // tick counter only moves forward
  a_tick_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> tick_q >= $past(tick_q))
    else $error("tick counter went backwards");

  // a compare always follows a table read
  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sspi_pkg::ST_SCAN_CMP |-> $past(rd_en))
    else $error("table compare without a preceding read");
`endif

endmodule

@@ hw/rtl/sspi_table.sv @@
// Waypoint table: one write port, one registered read port.
module sspi_table #(
  parameter int unsigned DEPTH  = sspi_pkg::MaxWaypointsDef,
  parameter int unsigned TIME_W = sspi_pkg::TimeBitsDef,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [AddrW-1:0]                  wr_addr_i,
  input  logic [TIME_W-1:0]                 wr_time_i,
  input  logic signed [sspi_pkg::SpeedW-1:0] wr_speed_i,
  input  logic                              rd_en_i,
  input  logic [AddrW-1:0]                  rd_addr_i,
  output logic [TIME_W-1:0]                 rd_time_o,
  output logic signed [sspi_pkg::SpeedW-1:0] rd_speed_o
);

  logic [TIME_W-1:0]                  time_mem  [DEPTH];
  logic signed [sspi_pkg::SpeedW-1:0] speed_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      time_mem[wr_addr_i]  <= wr_time_i;
      speed_mem[wr_addr_i] <= wr_speed_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_time_o  <= time_mem[rd_addr_i];
      rd_speed_o <= speed_mem[rd_addr_i];
    end
  end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the scheduled speed PI loop: directed corners, then random traffic.
module testbench;

  localparam int NumWaypoints  = sspi_pkg::MaxWaypointsDef;
  localparam int SettleCycles  = 60;    // longer than the worst tick latency
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 3000;

  typedef struct {
    sspi_pkg::opcode_e                   op;
    logic signed [sspi_pkg::SpeedW-1:0]  meas;
    logic                                present;
    logic [sspi_pkg::WpIdxW-1:0]         idx;
    logic [sspi_pkg::WpTimeW-1:0]        wtime;
    logic signed [sspi_pkg::SpeedW-1:0]  wspeed;
  } word_t;

  typedef struct {
    logic signed [sspi_pkg::CmdW-1:0]    cmd;
    logic                                lim_hit;
    logic signed [sspi_pkg::SpeedW-1:0]  target;
  } pi_result_t;

  logic                                  clk_i = 1'b0;
  logic                                  rst_ni;
  logic                                  cfg_valid_i;
  logic                                  cfg_ready_o;
  logic [sspi_pkg::CfgIdxW-1:0]          cfg_index_i;
  logic [sspi_pkg::CfgDataW-1:0]         cfg_data_i;
  logic                                  in_valid_i;
  logic                                  in_ready_o;
  logic                                  opcode_i;
  logic signed [sspi_pkg::SpeedW-1:0]    speed_measured_i;
  logic                                  speed_present_i;
  logic [sspi_pkg::WpIdxW-1:0]           waypoint_index_i;
  logic [sspi_pkg::WpTimeW-1:0]          waypoint_time_i;
  logic signed [sspi_pkg::SpeedW-1:0]    waypoint_speed_i;
  logic                                  out_valid_o;
  logic                                  out_ready_i;
  logic signed [sspi_pkg::CmdW-1:0]      current_command_o;
  logic                                  at_limit_o;
  logic signed [sspi_pkg::SpeedW-1:0]    speed_target_o;

  scheduled_speed_pi_loop u_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .opcode_i, .speed_measured_i, .speed_present_i,
    .waypoint_index_i, .waypoint_time_i, .waypoint_speed_i,
    .out_valid_o, .out_ready_i, .current_command_o, .at_limit_o, .speed_target_o
  );

  always #5 clk_i = ~clk_i;

  // loop model state
  longint                                kp_gain   = longint'(sspi_pkg::KpReset);
  longint                                ki_gain   = longint'(sspi_pkg::KiReset);
  longint                                lim_val   = longint'(sspi_pkg::LimitReset);
  logic [sspi_pkg::CountW-1:0]           wp_count  = sspi_pkg::CountReset;
  logic [sspi_pkg::WpTimeW-1:0]          tick_ctr  = '0;
  longint                                integ_acc = 0;
  bit                                    speed_seen = 1'b0;
  logic [sspi_pkg::WpTimeW-1:0]          wp_time [NumWaypoints];
  logic signed [sspi_pkg::SpeedW-1:0]    wp_speed [NumWaypoints];
  longint                                last_target = 0;

  pi_result_t                            pending_commands [$];
  pi_result_t                            oldest;
  int                                    fail_count = 0;
  bit                                    no_idle = 1'b0;
  bit                                    hold_output = 1'b0;
  int                                    quiet_cycles;

  function automatic longint sat_integral(input longint x);
    longint hi;
    hi = (longint'(1) <<< 47) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic pi_result_t run_tick(input word_t w);
    pi_result_t r;
    longint tgt, err, outv, clampv, limv;
    int n, i;
    bit found;
    tgt = 0;
    clampv = 0;
    found = 1'b0;
    r.lim_hit = 1'b0;
    if (tick_ctr != '1) tick_ctr = tick_ctr + 1;
    if (w.present) speed_seen = 1'b1;
    n = (wp_count > NumWaypoints) ? NumWaypoints : int'(wp_count);
    // highest loaded entry that has come due wins
    for (i = n - 1; i >= 0; i--) begin
      if (!found && tick_ctr >= wp_time[i]) begin
        tgt = longint'(wp_speed[i]);
        found = 1'b1;
      end
    end
    if (speed_seen) begin
      err = tgt - longint'(w.meas);
      integ_acc = sat_integral(integ_acc + ((ki_gain * err) >>> 8));
      outv = kp_gain * err + integ_acc;
      limv = lim_val * 65536;
      clampv = outv;
      if (clampv > limv) clampv = limv;
      if (clampv < -limv) clampv = -limv;
      if (clampv != outv) begin
        r.lim_hit = 1'b1;
        integ_acc = sat_integral(integ_acc - (outv - clampv));
      end
    end
    r.cmd = sspi_pkg::CmdW'(clampv >>> 16);
    r.target = tgt[sspi_pkg::SpeedW-1:0];
    last_target = tgt;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // speed close to the current target so the loop mostly runs unclamped
  function automatic logic signed [sspi_pkg::SpeedW-1:0] near_target();
    longint v;
    v = last_target + longint'(int'($urandom_range(0, 40000)) - 20000);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[sspi_pkg::SpeedW-1:0];
  endfunction

  function automatic logic [sspi_pkg::WpTimeW-1:0] rand_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return tick_ctr + $urandom_range(0, 300);
    if (r < 90) return $urandom_range(0, tick_ctr);
    return $urandom();
  endfunction

  function automatic logic signed [sspi_pkg::SpeedW-1:0] rand_speed();
    logic signed [sspi_pkg::SpeedW-1:0] s;
    if ($urandom_range(0, 99) < 80) begin
      s = sspi_pkg::SpeedW'(int'($urandom_range(0, 100000)) - 50000);
    end else begin
      s = sspi_pkg::SpeedW'($urandom());
    end
    return s;
  endfunction

  task automatic send_word(input word_t w);
    int gap;
    pi_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    opcode_i         <= w.op;
    speed_measured_i <= w.meas;
    speed_present_i  <= w.present;
    waypoint_index_i <= w.idx;
    waypoint_time_i  <= w.wtime;
    waypoint_speed_i <= w.wspeed;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (w.op == sspi_pkg::OP_TICK) begin
      res = run_tick(w);
      pending_commands = {pending_commands, res};
    end else begin
      wp_time[w.idx]  = w.wtime;
      wp_speed[w.idx] = w.wspeed;
    end
  endtask

  task automatic send_tick(input logic signed [sspi_pkg::SpeedW-1:0] meas,
                           input logic present);
    word_t w;
    w.op = sspi_pkg::OP_TICK;
    w.meas = meas;
    w.present = present;
    w.idx = sspi_pkg::WpIdxW'($urandom());
    w.wtime = $urandom();
    w.wspeed = sspi_pkg::SpeedW'($urandom());
    send_word(w);
  endtask

  task automatic send_waypoint(input logic [sspi_pkg::WpIdxW-1:0] idx,
                               input logic [sspi_pkg::WpTimeW-1:0] t,
                               input logic signed [sspi_pkg::SpeedW-1:0] s);
    word_t w;
    w.op = sspi_pkg::OP_WRITE;
    w.meas = sspi_pkg::SpeedW'($urandom());
    w.present = 1'($urandom());
    w.idx = idx;
    w.wtime = t;
    w.wspeed = s;
    send_word(w);
  endtask

  // let every outstanding tick finish before touching the registers
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input sspi_pkg::cfg_idx_e idx,
                           input logic [sspi_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      sspi_pkg::CFG_KP:    kp_gain  = longint'(data);
      sspi_pkg::CFG_KI:    ki_gain  = longint'(data);
      sspi_pkg::CFG_LIMIT: lim_val  = longint'(data[sspi_pkg::LimitW-1:0]);
      sspi_pkg::CFG_COUNT: wp_count = data[sspi_pkg::CountW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // output is zero and integral frozen until a measurement shows up
  task automatic test_before_first_speed();
    send_tick(24'sd5000, 1'b0);
    send_tick(-24'sd8388608, 1'b0);
    send_waypoint(4'd0, 32'd0, 24'sd0);  // present bit on a write must not count
    send_tick(24'sd1234, 1'b0);
    send_tick(-24'sd2560, 1'b1);
    send_tick(24'sd7680, 1'b0);          // this value is used although present is low
  endtask

  task automatic test_waypoint_table();
    int i;
    for (i = 0; i < NumWaypoints; i++)
      send_waypoint(sspi_pkg::WpIdxW'(i), tick_ctr + 4 * i, rand_speed());
    drain();
    write_reg(sspi_pkg::CFG_COUNT, 24'd16);
    for (i = 0; i < 4; i++) send_tick(near_target(), 1'b1);
  endtask

  // full-scale gains and errors drive the integral into saturation both ways
  task automatic test_gain_extremes();
    int i;
    drain();
    write_reg(sspi_pkg::CFG_KP, 24'hFFFFFF);
    write_reg(sspi_pkg::CFG_KI, 24'hFFFFFF);
    write_reg(sspi_pkg::CFG_LIMIT, 24'hFFFFFF);
    write_reg(sspi_pkg::CFG_COUNT, 24'd1);
    send_waypoint(4'd0, 32'd0, 24'sd8388607);
    for (i = 0; i < 3; i++) send_tick(-24'sd8388608, 1'b1);
    send_waypoint(4'd0, 32'd0, -24'sd8388608);
    for (i = 0; i < 3; i++) send_tick(24'sd8388607, 1'b1);
    drain();
    write_reg(sspi_pkg::CFG_KP, 24'd0);
    write_reg(sspi_pkg::CFG_KI, 24'd0);
    write_reg(sspi_pkg::CFG_LIMIT, 24'd0);
    send_tick(24'sd100, 1'b1);
    send_tick(-24'sd100, 1'b0);
  endtask

  task automatic test_count_limits();
    drain();
    write_reg(sspi_pkg::CFG_KP, sspi_pkg::KpReset);
    write_reg(sspi_pkg::CFG_KI, sspi_pkg::KiReset);
    write_reg(sspi_pkg::CFG_LIMIT, sspi_pkg::CfgDataW'(sspi_pkg::LimitReset));
    send_waypoint(4'd15, 32'hFFFFFFFF, 24'sd8388607);  // never comes due
    send_waypoint(4'd14, 32'd0, 24'sd3000);
    drain();
    write_reg(sspi_pkg::CFG_COUNT, 24'hFFFFFF);   // count 31, scan capped at table size
    send_tick(24'sd2900, 1'b1);
    send_tick(24'sd3100, 1'b1);
    drain();
    write_reg(sspi_pkg::CFG_COUNT, 24'hFFFFF1);   // count 17
    send_tick(24'sd3000, 1'b1);
    drain();
    write_reg(sspi_pkg::CFG_COUNT, 24'd0);
    send_tick(24'sd0, 1'b1);
  endtask

  task automatic test_random_traffic(input int n_items,
                                     input logic [sspi_pkg::CountW-1:0] count);
    int k, r;
    logic [sspi_pkg::CfgDataW-1:0] data;
    drain();
    write_reg(sspi_pkg::CFG_KP, sspi_pkg::CfgDataW'(($urandom_range(0, 4) == 0) ?
              $urandom() : $urandom_range(0, 131072)));
    write_reg(sspi_pkg::CFG_KI, sspi_pkg::CfgDataW'(($urandom_range(0, 4) == 0) ?
              $urandom() : $urandom_range(0, 2000000)));
    write_reg(sspi_pkg::CFG_LIMIT, sspi_pkg::CfgDataW'(($urandom_range(0, 3) == 0) ?
              $urandom() : $urandom_range(1000, 60000)));
    data = sspi_pkg::CfgDataW'($urandom());
    data[sspi_pkg::CountW-1:0] = count;
    write_reg(sspi_pkg::CFG_COUNT, data);
    for (k = 0; k < n_items; k++) begin
      no_idle = ((k / 40) % 5) == 4;
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_waypoint(sspi_pkg::WpIdxW'($urandom()), rand_time(), rand_speed());
      end else if (r < 90) begin
        send_tick(near_target(), $urandom_range(0, 9) != 0);
      end else begin
        send_tick(sspi_pkg::SpeedW'($urandom()), 1'($urandom_range(0, 1)));
      end
    end
    no_idle = 1'b0;
  endtask

  // stall the result side long enough that the input backs up
  task automatic test_backpressure();
    int k;
    hold_output = 1'b1;
    no_idle = 1'b1;
    for (k = 0; k < 30; k++) send_tick(near_target(), 1'b1);
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = sspi_pkg::CFG_KP;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    opcode_i         = sspi_pkg::OP_TICK;
    speed_measured_i = '0;
    speed_present_i  = 1'b0;
    waypoint_index_i = '0;
    waypoint_time_i  = '0;
    waypoint_speed_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_before_first_speed();
    test_waypoint_table();
    test_gain_extremes();
    test_count_limits();
    test_random_traffic(180, 5'd16);
    test_random_traffic(180, 5'd5);
    test_backpressure();
    test_random_traffic(180, 5'd0);
    test_random_traffic(180, 5'd31);
    test_random_traffic(180, 5'd9);
    test_random_traffic(180, 5'd1);
    drain();

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    int r, len;
    out_ready_i = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_output) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_output = 1'b0;
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
        @(negedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready_i <= 1'b1;
          len = $urandom_range(1, 8);
        end else if (r < 95) begin
          out_ready_i <= 1'b0;
          len = $urandom_range(1, 4);
        end else begin
          out_ready_i <= 1'b0;
          len = $urandom_range(20, 60);
        end
        repeat (len) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_commands.size() == 0) begin
        $error("result word with nothing outstanding: current_command %0d", current_command_o);
        fail_count++;
      end else begin
        oldest = pending_commands.pop_front();
        if (current_command_o !== oldest.cmd) begin
          $error("current_command: expected %0d, got %0d", oldest.cmd, current_command_o);
          fail_count++;
        end
        if (at_limit_o !== oldest.lim_hit) begin
          $error("at_limit: expected %0d, got %0d", oldest.lim_hit, at_limit_o);
          fail_count++;
        end
        if (speed_target_o !== oldest.target) begin
          $error("speed_target: expected %0d, got %0d", oldest.target, speed_target_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long without any word moving on any channel
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o) ||
          (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
